// File: rtl/core/cbig_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbig_pkg
// shared types and codes for the convolution input-gradient block
// ----------------------------------------------------------------------------
package cbig_pkg;

   // item actions
   localparam logic [1:0] ACTION_KERNEL = 2'd0;
   localparam logic [1:0] ACTION_GRAD   = 2'd1;
   localparam logic [1:0] ACTION_QUERY  = 2'd2;

   // csr register indexes
   localparam logic [2:0] CSR_OUT_CHANNELS = 3'd0;
   localparam logic [2:0] CSR_IN_CHANNELS  = 3'd1;
   localparam logic [2:0] CSR_KERNEL_ROWS  = 3'd2;
   localparam logic [2:0] CSR_KERNEL_COLS  = 3'd3;
   localparam logic [2:0] CSR_GRAD_ROWS    = 3'd4;
   localparam logic [2:0] CSR_GRAD_COLS    = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   typedef struct packed {
      logic [1:0]         action;
      logic [2:0]         out_chan;
      logic [2:0]         in_chan;
      logic [5:0]         row;
      logic [5:0]         col;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] grad_value;
      logic               saturated;
      logic               out_of_range;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage : cbig_pkg
`default_nettype wire

// File: rtl/core/conv_backward_input_gradient_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv_backward_input_gradient_top
// input gradient of a 2-d convolution layer as a full convolution
// ----------------------------------------------------------------------------
// usage:
//   req channel (valid/stall) carries load and query beats. a kernel or
//   gradient load beat writes one word into on-chip memory and returns
//   nothing. a query beat returns one rsp beat holding the summed
//   input-gradient element (q.12, 32 bits) and its flags.
//   csr channel (valid/ready) writes the six size registers; ready is always
//   high, writes are expected only while the block is idle.
// query flow:
//   a query walks out_channels x kernel_rows x kernel_cols taps through one
//   shared multiply-accumulate unit, one tap per cycle, at most 200 taps.
//   the memory read, multiply and accumulate stages drain behind the last
//   tap before the result is loaded. a query outside the result plane
//   skips the taps. req_stall is high while a query is in work.
// reset:
//   synchronous, active high; registers return to 1,1,3,3,32,32 and the
//   datapath goes idle. memory contents are undefined until written.
// rsp stall:
//   the result waits in the output register; new items are still taken, and
//   a following query finishes its sum and then holds until the register frees.
// ----------------------------------------------------------------------------
module conv_backward_input_gradient_top #(
   parameter int MAX_OUT_CHANNELS = 8,
   parameter int MAX_IN_CHANNELS  = 8,
   parameter int MAX_KERNEL_ROWS  = 5,
   parameter int MAX_KERNEL_COLS  = 5,
   parameter int MAX_GRAD_ROWS    = 32,
   parameter int MAX_GRAD_COLS    = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire cbig_pkg::req_type                     req_data,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output cbig_pkg::rsp_type                          rsp_data,
   // configuration write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [cbig_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [cbig_pkg::CSR_DATA_W-1:0]       csr_data
);
   import cbig_pkg::*;

   // memory geometry
   localparam int KDEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL_ROWS *
                           MAX_KERNEL_COLS;
   localparam int GDEPTH = MAX_OUT_CHANNELS * MAX_GRAD_ROWS * MAX_GRAD_COLS;
   localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
   localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;

   // ------------------------------------------------------------------
   // size registers
   // ------------------------------------------------------------------
   logic [3:0] out_channels_ff, in_channels_ff;
   logic [2:0] kernel_rows_ff, kernel_cols_ff;
   logic [5:0] grad_rows_ff, grad_cols_ff;

   logic csr_write;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_channels_ff <= 4'd1;
         in_channels_ff  <= 4'd1;
         kernel_rows_ff  <= 3'd3;
         kernel_cols_ff  <= 3'd3;
         grad_rows_ff    <= 6'd32;
         grad_cols_ff    <= 6'd32;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OUT_CHANNELS: out_channels_ff <= csr_data[3:0];
            CSR_IN_CHANNELS:  in_channels_ff  <= csr_data[3:0];
            CSR_KERNEL_ROWS:  kernel_rows_ff  <= csr_data[2:0];
            CSR_KERNEL_COLS:  kernel_cols_ff  <= csr_data[2:0];
            CSR_GRAD_ROWS:    grad_rows_ff    <= csr_data[5:0];
            CSR_GRAD_COLS:    grad_cols_ff    <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // effective sizes: zero reads as one, anything above the maximum as the maximum
   logic [3:0] noc, nic;
   logic [2:0] kr, kc;
   logic [5:0] gr, gc;

   always_comb begin
      noc = (out_channels_ff == '0) ? 4'd1 :
            ((32'(out_channels_ff) > MAX_OUT_CHANNELS) ? 4'(MAX_OUT_CHANNELS)
                                                       : out_channels_ff);
      nic = (in_channels_ff == '0) ? 4'd1 :
            ((32'(in_channels_ff) > MAX_IN_CHANNELS) ? 4'(MAX_IN_CHANNELS)
                                                     : in_channels_ff);
      kr  = (kernel_rows_ff == '0) ? 3'd1 :
            ((32'(kernel_rows_ff) > MAX_KERNEL_ROWS) ? 3'(MAX_KERNEL_ROWS)
                                                     : kernel_rows_ff);
      kc  = (kernel_cols_ff == '0) ? 3'd1 :
            ((32'(kernel_cols_ff) > MAX_KERNEL_COLS) ? 3'(MAX_KERNEL_COLS)
                                                     : kernel_cols_ff);
      gr  = (grad_rows_ff == '0) ? 6'd1 :
            ((32'(grad_rows_ff) > MAX_GRAD_ROWS) ? 6'(MAX_GRAD_ROWS) : grad_rows_ff);
      gc  = (grad_cols_ff == '0) ? 6'd1 :
            ((32'(grad_cols_ff) > MAX_GRAD_COLS) ? 6'(MAX_GRAD_COLS) : grad_cols_ff);
   end

   // ------------------------------------------------------------------
   // request decode
   // ------------------------------------------------------------------
   logic req_accept, is_query, kernel_we, grad_we, query_oor;
   logic [31:0] kwaddr_full, gwaddr_full;

   assign req_accept = req_valid && !req_stall;
   assign is_query   = (req_data.action == ACTION_QUERY);

   // loads beyond the store geometry are dropped
   assign kernel_we = req_accept && (req_data.action == ACTION_KERNEL) &&
                      (32'(req_data.out_chan) < MAX_OUT_CHANNELS) &&
                      (32'(req_data.in_chan) < MAX_IN_CHANNELS) &&
                      (32'(req_data.row) < MAX_KERNEL_ROWS) &&
                      (32'(req_data.col) < MAX_KERNEL_COLS);
   assign grad_we   = req_accept && (req_data.action == ACTION_GRAD) &&
                      (32'(req_data.out_chan) < MAX_OUT_CHANNELS) &&
                      (32'(req_data.row) < MAX_GRAD_ROWS) &&
                      (32'(req_data.col) < MAX_GRAD_COLS);

   assign kwaddr_full = ((32'(req_data.out_chan) * 32'(MAX_IN_CHANNELS) +
                          32'(req_data.in_chan)) * 32'(MAX_KERNEL_ROWS) +
                         32'(req_data.row)) * 32'(MAX_KERNEL_COLS) + 32'(req_data.col);
   assign gwaddr_full = (32'(req_data.out_chan) * 32'(MAX_GRAD_ROWS) +
                         32'(req_data.row)) * 32'(MAX_GRAD_COLS) + 32'(req_data.col);

   // result plane is in_channels x (gr+kr-1) x (gc+kc-1)
   assign query_oor = ({1'b0, req_data.in_chan} >= nic) ||
                      ({1'b0, req_data.row} >= (7'(gr) + 7'(kr) - 7'd1)) ||
                      ({1'b0, req_data.col} >= (7'(gc) + 7'(kc) - 7'd1));

   // ------------------------------------------------------------------
   // sequencer state
   // ------------------------------------------------------------------
   state_type state_ff, state_in;
   logic [3:0] ch_ff, ch_in;
   logic [2:0] u_ff, u_in, v_ff, v_in;
   logic [2:0] ic_ff;
   logic [5:0] row_ff, col_ff;
   logic       oor_ff, oor_in;
   logic [39:0] acc_ff, acc_in;
   logic       issue, last_tap, rsp_free, rsp_load;

   // pipeline control: memory read stage, multiply stage
   logic s1_vld_ff, s1_use_ff, s1_last_ff;
   logic s2_vld_ff, s2_last_ff;
   logic signed [31:0] prod_ff;

   assign issue    = (state_ff == ST_RUN);
   assign last_tap = (ch_ff == noc - 4'd1) && (v_ff == kc - 3'd1) && (u_ff == kr - 3'd1);
   assign rsp_free = !rsp_valid || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff  <= ch_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      oor_ff <= oor_in;
      acc_ff <= acc_in;
      if (req_accept && is_query) begin
         ic_ff  <= req_data.in_chan;
         row_ff <= req_data.row;
         col_ff <= req_data.col;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      ch_in     = ch_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      oor_in    = oor_ff;
      rsp_load  = 1'b0;
      // shared accumulator takes each product as it leaves the multiplier
      acc_in    = s2_vld_ff ? (acc_ff + {{8{prod_ff[31]}}, prod_ff}) : acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid && is_query) begin
               acc_in   = '0;
               ch_in    = '0;
               u_in     = '0;
               v_in     = '0;
               oor_in   = query_oor;
               state_in = query_oor ? ST_FINISH : ST_RUN;
            end
         end
         ST_RUN: begin
            // channel innermost, then kernel column, then kernel row
            if (ch_ff == noc - 4'd1) begin
               ch_in = '0;
               if (v_ff == kc - 3'd1) begin
                  v_in = '0;
                  u_in = u_ff + 3'd1;
               end else begin
                  v_in = v_ff + 3'd1;
               end
            end else begin
               ch_in = ch_ff + 4'd1;
            end
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s2_vld_ff && s2_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // tap address generation
   // ------------------------------------------------------------------
   logic signed [7:0] gi, gj;
   logic              tap_ok;
   logic [31:0]       kraddr_full, graddr_full;
   logic [KAW-1:0]    kraddr;
   logic [GAW-1:0]    graddr;

   // gradient position = query position + tap - (kernel size - 1)
   assign gi = $signed({2'b00, row_ff}) + $signed({5'b0, u_ff}) -
               $signed({5'b0, kr}) + 8'sd1;
   assign gj = $signed({2'b00, col_ff}) + $signed({5'b0, v_ff}) -
               $signed({5'b0, kc}) + 8'sd1;
   assign tap_ok = !gi[7] && !gj[7] && (gi[6:0] < {1'b0, gr}) && (gj[6:0] < {1'b0, gc});

   assign kraddr_full = ((32'(ch_ff) * 32'(MAX_IN_CHANNELS) + 32'(ic_ff)) *
                         32'(MAX_KERNEL_ROWS) + 32'(u_ff)) * 32'(MAX_KERNEL_COLS) +
                        32'(v_ff);
   assign graddr_full = (32'(ch_ff) * 32'(MAX_GRAD_ROWS) + 32'(gi[6:0])) *
                        32'(MAX_GRAD_COLS) + 32'(gj[6:0]);
   // taps off the plane read entry zero and are masked later
   assign kraddr = tap_ok ? kraddr_full[KAW-1:0] : '0;
   assign graddr = tap_ok ? graddr_full[GAW-1:0] : '0;

   // ------------------------------------------------------------------
   // on-chip stores, one write and one registered read port each
   // ------------------------------------------------------------------
   logic [15:0] kernel_mem [KDEPTH];
   logic [15:0] grad_mem   [GDEPTH];
   logic [15:0] krd_ff, grd_ff;

   always_ff @(posedge clock) begin
      if (kernel_we) begin
         kernel_mem[kwaddr_full[KAW-1:0]] <= req_data.value;
      end
      krd_ff <= kernel_mem[kraddr];
   end

   always_ff @(posedge clock) begin
      if (grad_we) begin
         grad_mem[gwaddr_full[GAW-1:0]] <= req_data.value;
      end
      grd_ff <= grad_mem[graddr];
   end

   // ------------------------------------------------------------------
   // multiply stage
   // ------------------------------------------------------------------
   logic signed [31:0] prod_in;
   assign prod_in = s1_use_ff ? ($signed(krd_ff) * $signed(grd_ff)) : 32'sd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
      s1_use_ff  <= tap_ok;
      s1_last_ff <= last_tap;
      s2_last_ff <= s1_last_ff;
      prod_ff    <= prod_in;
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   // floor shift by 12; a 40-bit sum shifted down to 28 bits always fits 32
   logic signed [31:0] grad_scaled;
   assign grad_scaled = oor_ff ? 32'sd0 : $signed({{4{acc_ff[39]}}, acc_ff[39:12]});

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff.grad_value   <= grad_scaled;
         rsp_data_ff.saturated    <= 1'b0;
         rsp_data_ff.out_of_range <= oor_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : conv_backward_input_gradient_top
`default_nettype wire

// File: dv/cbig_checker.sv
// ----------------------------------------------------------------------------
// cbig_checker
// watches the req, rsp and csr channels of the input-gradient block, keeps
// its own copy of the size registers and both stores, predicts every query
// result and compares each rsp beat with the oldest prediction
// ----------------------------------------------------------------------------
module cbig_checker
   import cbig_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire req_type                req_data,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire rsp_type                rsp_data,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output int unsigned                 mismatch_count,
   output int unsigned                 waiting_results,
   output int unsigned                 results_seen,
   output int unsigned                 flagged_seen
);

   localparam int MAX_OC = 8;
   localparam int MAX_IC = 8;
   localparam int MAX_KR = 5;
   localparam int MAX_KC = 5;
   localparam int MAX_GR = 32;
   localparam int MAX_GC = 32;
   localparam logic signed [39:0] Q_MAX = 40'sd2147483647;
   localparam logic signed [39:0] Q_MIN = -40'sd2147483648;

   logic [15:0] weight_mem [MAX_OC*MAX_IC*MAX_KR*MAX_KC];
   logic [15:0] grad_mem   [MAX_OC*MAX_GR*MAX_GC];

   logic [3:0] size_out_ch, size_in_ch;
   logic [2:0] size_krows, size_kcols;
   logic [5:0] size_grows, size_gcols;

   rsp_type     expected_grads [$];
   int unsigned miss_total;
   int unsigned result_total;
   int unsigned flagged_total;

   assign mismatch_count = miss_total;
   assign results_seen   = result_total;
   assign flagged_seen   = flagged_total;

   initial begin
      miss_total    = 0;
      result_total  = 0;
      flagged_total = 0;
   end

   task automatic report_mismatch(input string msg);
      if (miss_total < 40) begin
         $display("ERROR: %s", msg);
      end
      miss_total++;
   endtask

   function automatic int size_in_use(input int raw, input int maxv);
      if (raw == 0) return 1;
      if (raw > maxv) return maxv;
      return raw;
   endfunction

   // full convolution over the stores, q.24 products into a 40-bit sum
   function automatic rsp_type predict_input_gradient(input logic [2:0] ic,
                                                      input logic [5:0] r,
                                                      input logic [5:0] c);
      int noc, nic, kr, kc, gr, gc;
      int rr, cc, gi, gj, u, v, ch;
      logic signed [31:0] prod;
      logic signed [39:0] acc;
      logic signed [39:0] scaled;
      rsp_type res;
      noc = size_in_use(size_out_ch, MAX_OC);
      nic = size_in_use(size_in_ch, MAX_IC);
      kr  = size_in_use(size_krows, MAX_KR);
      kc  = size_in_use(size_kcols, MAX_KC);
      gr  = size_in_use(size_grows, MAX_GR);
      gc  = size_in_use(size_gcols, MAX_GC);
      rr  = r;
      cc  = c;
      res = '0;
      acc = '0;
      if (ic >= nic || rr >= gr + kr - 1 || cc >= gc + kc - 1) begin
         res.out_of_range = 1'b1;
         return res;
      end
      for (u = 0; u < kr; u++) begin
         gi = rr + u - (kr - 1);
         if (gi < 0 || gi >= gr) continue;
         for (v = 0; v < kc; v++) begin
            gj = cc + v - (kc - 1);
            if (gj < 0 || gj >= gc) continue;
            for (ch = 0; ch < noc; ch++) begin
               prod = $signed(weight_mem[((ch*MAX_IC + ic)*MAX_KR + u)*MAX_KC + v])
                    * $signed(grad_mem[(ch*MAX_GR + gi)*MAX_GC + gj]);
               acc  = acc + prod;
            end
         end
      end
      // arithmetic shift rounds toward minus infinity
      scaled = acc >>> 12;
      if (scaled > Q_MAX) begin
         scaled        = Q_MAX;
         res.saturated = 1'b1;
      end else if (scaled < Q_MIN) begin
         scaled        = Q_MIN;
         res.saturated = 1'b1;
      end
      res.grad_value = scaled[31:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_grads.delete();
         size_out_ch     = 4'd1;
         size_in_ch      = 4'd1;
         size_krows      = 3'd3;
         size_kcols      = 3'd3;
         size_grows      = 6'd32;
         size_gcols      = 6'd32;
         waiting_results <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OUT_CHANNELS: size_out_ch = csr_data[3:0];
               CSR_IN_CHANNELS:  size_in_ch  = csr_data[3:0];
               CSR_KERNEL_ROWS:  size_krows  = csr_data[2:0];
               CSR_KERNEL_COLS:  size_kcols  = csr_data[2:0];
               CSR_GRAD_ROWS:    size_grows  = csr_data[5:0];
               CSR_GRAD_COLS:    size_gcols  = csr_data[5:0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            result_total++;
            if (rsp_data.out_of_range) flagged_total++;
            if (expected_grads.size() == 0) begin
               report_mismatch($sformatf("result beat %0d with no query waiting",
                                         result_total));
            end else begin
               want = expected_grads.pop_front();
               if (rsp_data.grad_value !== want.grad_value)
                  report_mismatch($sformatf("result %0d grad_value got %0d want %0d",
                                            result_total, rsp_data.grad_value,
                                            want.grad_value));
               if (rsp_data.saturated !== want.saturated)
                  report_mismatch($sformatf("result %0d saturated got %b want %b",
                                            result_total, rsp_data.saturated,
                                            want.saturated));
               if (rsp_data.out_of_range !== want.out_of_range)
                  report_mismatch($sformatf("result %0d out_of_range got %b want %b",
                                            result_total, rsp_data.out_of_range,
                                            want.out_of_range));
            end
         end

         if (req_valid && !req_stall) begin
            case (req_data.action)
               ACTION_KERNEL: begin
                  if (req_data.row < MAX_KR && req_data.col < MAX_KC)
                     weight_mem[((req_data.out_chan*MAX_IC + req_data.in_chan)*MAX_KR
                                 + req_data.row)*MAX_KC + req_data.col] = req_data.value;
               end
               ACTION_GRAD: begin
                  if (req_data.row < MAX_GR && req_data.col < MAX_GC)
                     grad_mem[(req_data.out_chan*MAX_GR + req_data.row)*MAX_GC
                              + req_data.col] = req_data.value;
               end
               ACTION_QUERY: begin
                  expected_grads.push_back(predict_input_gradient(req_data.in_chan,
                                                                  req_data.row,
                                                                  req_data.col));
               end
               default: ;
            endcase
         end

         waiting_results <= expected_grads.size();
      end
   end

endmodule : cbig_checker

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the convolution input-gradient block: directed
// corner beats, then random load and query traffic over ten size settings,
// with bursty req traffic and patterned rsp stalls; checking is done by
// cbig_checker beside the block
// ----------------------------------------------------------------------------
module tb_top;
   import cbig_pkg::*;

   localparam int MAX_OC = 8;
   localparam int MAX_IC = 8;
   localparam int MAX_KR = 5;
   localparam int MAX_KC = 5;
   localparam int MAX_GR = 32;
   localparam int MAX_GC = 32;

   localparam int ITEM_TARGET   = 1450;
   localparam int SETTING_COUNT = 10;
   // long enough for the longest query, so this covers any work still in flight
   localparam int SETTLE_CYCLES = 250;
   localparam int CYCLE_LIMIT   = 3000000;

   // codes the block has no name for
   localparam logic [1:0] ACTION_NONE    = 2'd3;
   localparam logic [2:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [2:0] CSR_SPARE_HIGH = 3'd7;

   typedef enum int {FILL_RANDOM, FILL_MOST_NEG, FILL_MOST_POS} fill_mode_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   int unsigned mismatch_count;
   int unsigned waiting_results;
   int unsigned results_seen;
   int unsigned flagged_seen;

   conv_backward_input_gradient_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   cbig_checker u_grad_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .waiting_results (waiting_results),
      .results_seen    (results_seen),
      .flagged_seen    (flagged_seen)
   );

   // 4 time unit clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hard stop in case the block hangs
   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still waiting",
                  cycle_count, waiting_results);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // rsp side stalls on its own pattern: stretches of no stall, light and
   // heavy random stall, and long solid stall runs
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_run  = 0;
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_run  = $urandom_range(16, 200);
      end
      stall_run--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 4) != 0);
         default:     rsp_stall <= ((stall_run % 40) < 25);
      endcase
   end

   // sizes in use now, after the block's clamping of zero and oversize values
   int use_oc = 1, use_ic = 1, use_kr = 3, use_kc = 3, use_gr = 32, use_gc = 32;

   // which store words hold data, so that no query ever reads an unwritten one
   bit weight_loaded [MAX_OC*MAX_IC*MAX_KR*MAX_KC];
   bit sample_loaded [MAX_OC*MAX_GR*MAX_GC];

   int burst_left    = 0;
   int counted_beats = 0;
   int query_beats   = 0;
   int ignored_beats = 0;
   int setting_total = 1;

   function automatic int size_in_use(input int raw, input int maxv);
      if (raw == 0) return 1;
      if (raw > maxv) return maxv;
      return raw;
   endfunction

   function automatic int weight_slot(input int oc, input int ic, input int u, input int v);
      return ((oc*MAX_IC + ic)*MAX_KR + u)*MAX_KC + v;
   endfunction

   function automatic int sample_slot(input int oc, input int r, input int c);
      return (oc*MAX_GR + r)*MAX_GC + c;
   endfunction

   function automatic logic [15:0] pick_sample(input fill_mode_type mode);
      case (mode)
         FILL_MOST_NEG: return 16'h8000;
         FILL_MOST_POS: return 16'h7fff;
         default: begin
            case ($urandom_range(0, 15))
               0:       return 16'h8000;
               1:       return 16'h7fff;
               default: return 16'($urandom);
            endcase
         end
      endcase
   endfunction

   function automatic req_type make_beat(input logic [1:0] act, input int oc, input int ic,
                                         input int r, input int c, input logic [15:0] val);
      req_type b;
      b.action   = act;
      b.out_chan = 3'(oc);
      b.in_chan  = 3'(ic);
      b.row      = 6'(r);
      b.col      = 6'(c);
      b.value    = val;
      return b;
   endfunction

   // query position, mostly near the top-left corner so footprints get reused,
   // sometimes anywhere, sometimes on the last row or column
   function automatic int query_pos(input int span);
      int k;
      k = $urandom_range(0, 9);
      if (k < 6) return $urandom_range(0, (span - 1 < 7) ? span - 1 : 7);
      if (k < 8) return $urandom_range(0, span - 1);
      return span - 1;
   endfunction

   // one req beat; the sender works in bursts with gaps in between, and now
   // and then a long burst with no gap at all
   task automatic issue(input req_type beat);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(30, 80);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic load_weight(input int oc, input int ic, input int u, input int v,
                              input logic [15:0] val);
      issue(make_beat(ACTION_KERNEL, oc, ic, u, v, val));
      if (u < MAX_KR && v < MAX_KC) begin
         weight_loaded[weight_slot(oc, ic, u, v)] = 1'b1;
         counted_beats++;
      end else begin
         ignored_beats++;
      end
   endtask

   task automatic load_sample(input int oc, input int r, input int c,
                              input logic [15:0] val);
      issue(make_beat(ACTION_GRAD, oc, $urandom_range(0, 7), r, c, val));
      if (r < MAX_GR && c < MAX_GC) begin
         sample_loaded[sample_slot(oc, r, c)] = 1'b1;
         counted_beats++;
      end else begin
         ignored_beats++;
      end
   endtask

   task automatic send_query(input int ic, input int r, input int c);
      issue(make_beat(ACTION_QUERY, $urandom_range(0, 7), ic, r, c, 16'($urandom)));
      counted_beats++;
      query_beats++;
   endtask

   // a query inside the result plane; every weight and sample its sum touches
   // is loaded first if it has never been written
   task automatic ask_gradient(input int ic, input int r, input int c,
                               input fill_mode_type mode);
      int gi, gj, u, v, ch;
      if (ic < use_ic && r < use_gr + use_kr - 1 && c < use_gc + use_kc - 1) begin
         for (u = 0; u < use_kr; u++) begin
            gi = r + u - (use_kr - 1);
            if (gi < 0 || gi >= use_gr) continue;
            for (v = 0; v < use_kc; v++) begin
               gj = c + v - (use_kc - 1);
               if (gj < 0 || gj >= use_gc) continue;
               for (ch = 0; ch < use_oc; ch++) begin
                  if (!weight_loaded[weight_slot(ch, ic, u, v)])
                     load_weight(ch, ic, u, v, pick_sample(mode));
                  if (!sample_loaded[sample_slot(ch, gi, gj)])
                     load_sample(ch, gi, gj, pick_sample(mode));
               end
            end
         end
      end
      send_query(ic, r, c);
   endtask

   // a query past the channel count, the last row or the last column
   task automatic ask_outside();
      int sel;
      sel = $urandom_range(0, 2);
      if (sel == 0 && use_ic < MAX_IC)
         send_query($urandom_range(use_ic, 7), $urandom_range(0, 63), $urandom_range(0, 63));
      else if (sel <= 1)
         send_query($urandom_range(0, 7), $urandom_range(use_gr + use_kr - 1, 63),
                    $urandom_range(0, 63));
      else
         send_query($urandom_range(0, 7), $urandom_range(0, 63),
                    $urandom_range(use_gc + use_kc - 1, 63));
   endtask

   task automatic random_step();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         // well-formed query, footprint filled on demand
         ask_gradient($urandom_range(0, use_ic - 1), query_pos(use_gr + use_kr - 1),
                      query_pos(use_gc + use_kc - 1), FILL_RANDOM);
      end else if (pick < 60) begin
         ask_outside();
      end else if (pick < 80) begin
         // overwrite inside the region the current sizes use
         if ($urandom_range(0, 1))
            load_weight($urandom_range(0, use_oc - 1), $urandom_range(0, use_ic - 1),
                        $urandom_range(0, use_kr - 1), $urandom_range(0, use_kc - 1),
                        pick_sample(FILL_RANDOM));
         else
            load_sample($urandom_range(0, use_oc - 1), $urandom_range(0, use_gr - 1),
                        $urandom_range(0, use_gc - 1), pick_sample(FILL_RANDOM));
      end else if (pick < 90) begin
         // anywhere in the stores, in use now or not
         if ($urandom_range(0, 1))
            load_weight($urandom_range(0, 7), $urandom_range(0, 7),
                        $urandom_range(0, MAX_KR - 1), $urandom_range(0, MAX_KC - 1),
                        pick_sample(FILL_RANDOM));
         else
            load_sample($urandom_range(0, 7), $urandom_range(0, MAX_GR - 1),
                        $urandom_range(0, MAX_GC - 1), pick_sample(FILL_RANDOM));
      end else if (pick < 96) begin
         // loads beyond the store bounds, dropped by the block
         if ($urandom_range(0, 1))
            load_weight($urandom_range(0, 7), $urandom_range(0, 7),
                        $urandom_range(MAX_KR, 63), $urandom_range(0, 63),
                        pick_sample(FILL_RANDOM));
         else
            load_sample($urandom_range(0, 7), $urandom_range(0, 63),
                        $urandom_range(MAX_GC, 63), pick_sample(FILL_RANDOM));
      end else begin
         issue(make_beat(ACTION_NONE, $urandom_range(0, 7), $urandom_range(0, 7),
                         $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom)));
         ignored_beats++;
      end
   endtask

   task automatic run_random(input int budget);
      int first_beats, first_queries;
      first_beats   = counted_beats;
      first_queries = query_beats;
      while (counted_beats - first_beats < budget || query_beats - first_queries < 6)
         random_step();
   endtask

   // drop valid, wait for every result, then let any dropped work finish
   task automatic quiesce();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (waiting_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr beat with the unused upper data bits randomized
   task automatic write_size_reg(input logic [2:0] idx, input int val, input int width);
      logic [7:0] mask;
      logic [7:0] word;
      mask = 8'((1 << width) - 1);
      word = (8'($urandom) & ~mask) | (8'(val) & mask);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= word;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_sizes(input int oc, input int ic, input int kr, input int kc,
                              input int gr, input int gc);
      quiesce();
      write_size_reg(CSR_OUT_CHANNELS, oc, 4);
      write_size_reg(CSR_IN_CHANNELS, ic, 4);
      write_size_reg(CSR_KERNEL_ROWS, kr, 3);
      write_size_reg(CSR_KERNEL_COLS, kc, 3);
      write_size_reg(CSR_GRAD_ROWS, gr, 6);
      write_size_reg(CSR_GRAD_COLS, gc, 6);
      // writes to the unused indexes must change nothing
      write_size_reg(CSR_SPARE_LOW, $urandom_range(0, 255), 8);
      write_size_reg(CSR_SPARE_HIGH, $urandom_range(0, 255), 8);
      csr_valid <= 1'b0;
      @(posedge clock);
      use_oc = size_in_use(oc, MAX_OC);
      use_ic = size_in_use(ic, MAX_IC);
      use_kr = size_in_use(kr, MAX_KR);
      use_kc = size_in_use(kc, MAX_KC);
      use_gr = size_in_use(gr, MAX_GR);
      use_gc = size_in_use(gc, MAX_GC);
      setting_total++;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset sizes (1 out, 1 in, 3x3 kernel, 32x32 plane)
      // loads past the store bounds and the unused action are dropped
      load_weight(7, 7, 5, 4, 16'h5a5a);
      load_weight(0, 0, 63, 63, 16'hffff);
      load_sample(7, 32, 0, 16'ha5a5);
      load_sample(0, 0, 63, 16'hffff);
      issue(make_beat(ACTION_NONE, 7, 7, 63, 63, 16'hffff));
      ignored_beats++;
      // queries past the channel count, the last row and the last column
      send_query(7, 0, 0);
      send_query(0, 34, 0);
      send_query(0, 0, 63);
      // corner sums with the most negative and most positive samples
      ask_gradient(0, 0, 0, FILL_MOST_NEG);
      ask_gradient(0, 33, 33, FILL_MOST_POS);
      ask_gradient(0, 1, 0, FILL_MOST_POS);
      ask_gradient(0, 33, 0, FILL_MOST_NEG);

      run_random(ITEM_TARGET / SETTING_COUNT);

      // widest channels and kernel on a small plane
      apply_sizes(8, 8, 5, 5, 6, 5);
      run_random(ITEM_TARGET / SETTING_COUNT);
      // zero or one everywhere clamps to the smallest sizes
      apply_sizes(0, 0, 0, 1, 1, 0);
      run_random(ITEM_TARGET / SETTING_COUNT);
      // oversize values clamp to the largest sizes
      apply_sizes(15, 12, 7, 6, 63, 40);
      run_random(ITEM_TARGET / SETTING_COUNT);
      apply_sizes(3, 5, 2, 4, 32, 3);
      run_random(ITEM_TARGET / SETTING_COUNT);
      apply_sizes(1, 8, 5, 1, 2, 32);
      run_random(ITEM_TARGET / SETTING_COUNT);
      apply_sizes(8, 1, 1, 5, 32, 1);
      run_random(ITEM_TARGET / SETTING_COUNT);
      repeat (3) begin
         apply_sizes($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
                     $urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 63));
         run_random(ITEM_TARGET / SETTING_COUNT);
      end

      quiesce();

      $display("sent %0d load and query beats plus %0d dropped beats over %0d size settings",
               counted_beats, ignored_beats, setting_total);
      $display("compared %0d results, %0d of them flagged outside the result plane",
               results_seen, flagged_seen);
      if (mismatch_count == 0 && waiting_results == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule : tb_top
